// ===== rtl/orsb_pkg.sv =====
// Package with the constants and types shared by the sample ring buffer files.
`default_nettype none
package orsb_pkg;

  // Ring geometry. One slot always stays free, so the ring holds RING_SIZE-1 entries.
  localparam int RING_SIZE = 64;
  localparam int IDX_W     = $clog2(RING_SIZE);
  localparam int REM_W     = $clog2(RING_SIZE + 1);

  // Field widths of the beats.
  localparam int SAMPLE_W  = 64;
  localparam int OVR_W     = 16;
  localparam int LIM_W     = 7;
  localparam int POS_W     = 6;
  localparam int S_DATA_W  = 88;
  localparam int M_DATA_W  = 80;

  // A drain never reports more positions than fit in the position field.
  localparam logic [LIM_W-1:0] LIMIT_MAX = LIM_W'(64);

  // Request kinds carried in s_tuser.
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_DRAIN,
    ST_FETCH
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/overwrite_ring_sample_buffer_unit.sv =====
// Top level of the overwrite-oldest ring buffer for counter samples.
//
// Requests arrive as beats on the s_ channel; s_tuser selects a tick (0) or a
// drain (1). A tick writes its sample into the ring and then one zero for each
// further missed period, one ring slot per cycle: a tick with an overrun count
// of zero or one writes only its sample, a larger count n writes min(n, 64) slots.
// A tick produces no output beat. When the ring is full the oldest entry drops.
// A drain walks the ring newest first and sends one m_ beat per entry, up to the
// read limit, with m_tlast on the final beat; it then empties the ring. Every
// entry is addressed in the sample RAM in ST_DRAIN and read back through the
// registered read in ST_FETCH; s_tready stays low until the drain is done.
// An empty drain sends a single beat with m_tuser low.
// Results sit in an output register, so a new request is taken while the last
// beat of a drain still waits; a stall on m_tready holds the drain walk.
// Synchronous reset empties the ring and drops any pending beat; the sample
// RAM itself is not cleared, since only written slots are ever read.
`default_nettype none
module overwrite_ring_sample_buffer_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // s_tdata: sample_value[63:0], overrun_count[79:64], read_limit[86:80], zero[87]
  input  wire logic [orsb_pkg::S_DATA_W-1:0] s_tdata,
  // s_tuser: func
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // m_tdata: out_value[63:0], out_position[69:64], delivered_count[75:70], zero[79:76]
  output logic      [orsb_pkg::M_DATA_W-1:0] m_tdata,
  // m_tuser: has_value
  output logic                               m_tuser,
  output logic                               m_tlast
);

  import orsb_pkg::*;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(RING_SIZE - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(RING_SIZE - 1) : i - 1'b1;
  endfunction

  // Input fields.
  logic [SAMPLE_W-1:0] in_sample;
  logic [OVR_W-1:0]    in_overrun;
  logic [LIM_W-1:0]    in_limit;

  assign in_sample  = s_tdata[SAMPLE_W-1:0];
  assign in_overrun = s_tdata[SAMPLE_W +: OVR_W];
  assign in_limit   = s_tdata[SAMPLE_W + OVR_W +: LIM_W];

  // Control registers.
  state_t            state, state_next;
  logic [IDX_W-1:0]  newest, newest_next;
  logic [IDX_W-1:0]  oldest, oldest_next;
  logic [REM_W-1:0]  remain, remain_next;
  logic [LIM_W-1:0]  limit, limit_next;
  logic [LIM_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic              out_valid, out_valid_next;

  // Output payload registers.
  logic [SAMPLE_W-1:0] out_value, out_value_next;
  logic [POS_W-1:0]    out_pos, out_pos_next;
  logic [POS_W-1:0]    out_cnt, out_cnt_next;
  logic                out_has, out_has_next;
  logic                out_last, out_last_next;

  // RAM ports.
  logic                ram_wr_en;
  logic [IDX_W-1:0]    ram_wr_addr;
  logic [SAMPLE_W-1:0] ram_wr_data;
  logic                ram_rd_en;
  logic [SAMPLE_W-1:0] ram_rd_data;

  logic              out_free;
  logic [REM_W-1:0]  push_total;
  logic [IDX_W-1:0]  push_slot;
  logic              fetch_last;

  assign out_free  = !out_valid || m_tready;
  assign push_slot = ring_next(newest);

  // Overrun count of zero still pushes the sample; the count saturates at the ring size.
  always_comb begin
    if (in_overrun == '0) begin
      push_total = REM_W'(1);
    end else if (in_overrun > OVR_W'(RING_SIZE)) begin
      push_total = REM_W'(RING_SIZE);
    end else begin
      push_total = in_overrun[REM_W-1:0];
    end
  end

  assign fetch_last = ((count + 1'b1) == limit) || (ring_prev(idx) == oldest);

  always_comb begin
    state_next     = state;
    newest_next    = newest;
    oldest_next    = oldest;
    remain_next    = remain;
    limit_next     = limit;
    count_next     = count;
    idx_next       = idx;
    out_valid_next = out_valid && !m_tready;
    out_value_next = out_value;
    out_pos_next   = out_pos;
    out_cnt_next   = out_cnt;
    out_has_next   = out_has;
    out_last_next  = out_last;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = push_slot;
    ram_wr_data    = '0;
    ram_rd_en      = 1'b0;
    s_tready       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == FUNC_TICK) begin
            ram_wr_en   = 1'b1;
            ram_wr_data = in_sample;
            newest_next = push_slot;
            if (push_slot == oldest) begin
              oldest_next = ring_next(oldest);
            end
            remain_next = push_total - 1'b1;
            if (push_total != REM_W'(1)) begin
              state_next = ST_PUSH;
            end
          end else begin
            limit_next = (in_limit > LIMIT_MAX) ? LIMIT_MAX : in_limit;
            count_next = '0;
            idx_next   = newest;
            state_next = ST_DRAIN;
          end
        end
      end

      ST_PUSH: begin
        ram_wr_en   = 1'b1;
        newest_next = push_slot;
        if (push_slot == oldest) begin
          oldest_next = ring_next(oldest);
        end
        remain_next = remain - 1'b1;
        if (remain == REM_W'(1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_DRAIN: begin
        if ((count < limit) && (idx != oldest)) begin
          ram_rd_en  = 1'b1;
          state_next = ST_FETCH;
        end else if (out_free) begin
          // Nothing to deliver: a single beat without a value closes the drain.
          out_valid_next = 1'b1;
          out_value_next = '0;
          out_pos_next   = '0;
          out_cnt_next   = '0;
          out_has_next   = 1'b0;
          out_last_next  = 1'b1;
          newest_next    = '0;
          oldest_next    = '0;
          state_next     = ST_IDLE;
        end
      end

      ST_FETCH: begin
        // The RAM read data holds until the next read, so a stall just waits here.
        if (out_free) begin
          out_valid_next = 1'b1;
          out_value_next = ram_rd_data;
          out_pos_next   = POS_W'(limit - 1'b1 - count);
          out_cnt_next   = POS_W'(count + 1'b1);
          out_has_next   = 1'b1;
          out_last_next  = fetch_last;
          if (fetch_last) begin
            newest_next = '0;
            oldest_next = '0;
            state_next  = ST_IDLE;
          end else begin
            count_next = count + 1'b1;
            idx_next   = ring_prev(idx);
            state_next = ST_DRAIN;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      newest    <= '0;
      oldest    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      newest    <= newest_next;
      oldest    <= oldest_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    remain    <= remain_next;
    limit     <= limit_next;
    count     <= count_next;
    idx       <= idx_next;
    out_value <= out_value_next;
    out_pos   <= out_pos_next;
    out_cnt   <= out_cnt_next;
    out_has   <= out_has_next;
    out_last  <= out_last_next;
  end

  orsb_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(RING_SIZE)
  ) u_ring (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(idx),
    .rd_data(ram_rd_data)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_DATA_W - SAMPLE_W - 2 * POS_W){1'b0}}, out_cnt, out_pos, out_value};
  assign m_tuser  = out_has;
  assign m_tlast  = out_last;

endmodule
`default_nettype wire

// ===== rtl/orsb_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module orsb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== bench/overwrite_ring_sample_buffer_unit_tb.sv =====
// Self-checking testbench for the overwrite-oldest sample ring buffer unit.
`default_nettype none
module overwrite_ring_sample_buffer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import orsb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct {
    logic                func;
    logic [SAMPLE_W-1:0] sample;
    logic [OVR_W-1:0]    overrun;
    logic [LIM_W-1:0]    limit;
  } request_t;

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    logic [POS_W-1:0]    position;
    logic                has_value;
    logic [POS_W-1:0]    delivered;
    logic                last;
  } drain_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = FUNC_TICK;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  overwrite_ring_sample_buffer_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  request_t    pending_requests[$];
  drain_beat_t drain_beats_due[$];

  // Shadow copy of the ring and its two markers.
  logic [SAMPLE_W-1:0] ring_shadow[RING_SIZE];
  logic [IDX_W-1:0]    shadow_oldest = '0;
  logic [IDX_W-1:0]    shadow_newest = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int beats_offered = 0;
  int beats_taken = 0;
  int error_count = 0;
  int cycle_count = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(RING_SIZE - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] slot_before(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(RING_SIZE - 1) : i - 1'b1;
  endfunction

  task automatic shadow_push(input logic [SAMPLE_W-1:0] v);
    shadow_newest = slot_after(shadow_newest);
    if (shadow_newest == shadow_oldest) begin
      shadow_oldest = slot_after(shadow_oldest);
    end
    ring_shadow[shadow_newest] = v;
  endtask

  // Updates the shadow ring for one accepted request and queues the drain beats it causes.
  task automatic predict_request(input request_t req);
    int          pushes;
    int          lim;
    int          count;
    logic [IDX_W-1:0] idx;
    drain_beat_t beat;
    if (req.func == FUNC_TICK) begin
      pushes = (req.overrun == '0) ? 1 : int'(req.overrun);
      if (pushes > RING_SIZE) begin
        pushes = RING_SIZE;
      end
      shadow_push(req.sample);
      for (int k = 1; k < pushes; k++) begin
        shadow_push('0);
      end
    end else begin
      lim = (req.limit > LIMIT_MAX) ? int'(LIMIT_MAX) : int'(req.limit);
      idx = shadow_newest;
      count = 0;
      while (count < lim && idx != shadow_oldest) begin
        beat.value     = ring_shadow[idx];
        beat.position  = POS_W'(lim - 1 - count);
        beat.has_value = 1'b1;
        beat.delivered = POS_W'(count + 1);
        beat.last      = (count + 1 == lim) || (slot_before(idx) == shadow_oldest);
        drain_beats_due.push_back(beat);
        count++;
        idx = slot_before(idx);
      end
      if (count == 0) begin
        beat = '{value: '0, position: '0, has_value: 1'b0, delivered: '0, last: 1'b1};
        drain_beats_due.push_back(beat);
      end
      shadow_oldest = '0;
      shadow_newest = '0;
    end
  endtask

  // Request driver: holds a beat until it is taken, then maybe idles; it also drives m_tready with random stalls.
  always @(negedge clk) begin
    request_t req;
    if (!rst) begin
      if (!(s_tvalid && beats_taken != beats_offered)) begin
        if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req = pending_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= req.func;
          s_tdata  <= {1'b0, req.limit, req.overrun, req.sample};
          beats_offered <= beats_offered + 1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: checks output beats against the oldest expectation, predicts on input beats.
  always @(posedge clk) begin
    request_t    req;
    drain_beat_t exp_beat;
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (drain_beats_due.size() == 0) begin
          $error("unexpected output beat: out_value=%h", m_tdata[63:0]);
          error_count++;
        end else begin
          exp_beat = drain_beats_due.pop_front();
          if (m_tdata[63:0] !== exp_beat.value) begin
            $error("out_value: expected %h, got %h", exp_beat.value, m_tdata[63:0]);
            error_count++;
          end
          if (m_tdata[69:64] !== exp_beat.position) begin
            $error("out_position: expected %0d, got %0d", exp_beat.position, m_tdata[69:64]);
            error_count++;
          end
          if (m_tuser !== exp_beat.has_value) begin
            $error("has_value: expected %0d, got %0d", exp_beat.has_value, m_tuser);
            error_count++;
          end
          if (m_tdata[75:70] !== exp_beat.delivered) begin
            $error("delivered_count: expected %0d, got %0d", exp_beat.delivered,
                   m_tdata[75:70]);
            error_count++;
          end
          if (m_tlast !== exp_beat.last) begin
            $error("last: expected %0d, got %0d", exp_beat.last, m_tlast);
            error_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        req.func    = s_tuser;
        req.sample  = s_tdata[63:0];
        req.overrun = s_tdata[79:64];
        req.limit   = s_tdata[86:80];
        predict_request(req);
        beats_taken <= beats_taken + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("overwrite_ring_sample_buffer_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic add_tick(input logic [SAMPLE_W-1:0] sample, input logic [OVR_W-1:0] overrun);
    pending_requests.push_back('{func: FUNC_TICK, sample: sample, overrun: overrun, limit: '0});
  endtask

  task automatic add_drain(input logic [LIM_W-1:0] limit);
    pending_requests.push_back('{func: FUNC_DRAIN, sample: '0, overrun: '0, limit: limit});
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [OVR_W-1:0] pick_overrun();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return OVR_W'($urandom_range(0, 1));
    if (r < 90) return OVR_W'($urandom_range(2, 70));
    return OVR_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [LIM_W-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 25) return LIMIT_MAX;
    if (r < 35) return LIM_W'($urandom_range(65, 127));
    return LIM_W'($urandom_range(1, 63));
  endfunction

  // Mostly runs of ticks closed by a drain; the rest are lone drains and stray ticks.
  task automatic add_random_items(input int target);
    int added;
    int run_len;
    int r;
    added = 0;
    while (added < target) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        add_drain(pick_limit());
        added++;
      end else if (r < 15) begin
        add_tick(pick_sample(), pick_overrun());
        added++;
      end else begin
        // The run is cut short so that the phase ends on its target count.
        run_len = $urandom_range(1, 40);
        if (run_len > target - added - 1) begin
          run_len = target - added - 1;
        end
        for (int k = 0; k < run_len; k++) begin
          add_tick(pick_sample(), pick_overrun());
        end
        add_drain(pick_limit());
        added += run_len + 1;
      end
    end
  endtask

  task automatic wait_queue_sent();
    while (pending_requests.size() > 0 || beats_taken != beats_offered) begin
      @(posedge clk);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty drains, zero and clamped overruns, wrap, saturated limit.
    add_drain(LIM_W'(5));
    add_drain('0);
    add_tick('1, '0);
    add_tick('0, OVR_W'(1));
    add_drain('0);
    add_drain(LIM_W'(3));
    add_tick(64'h0123_4567_89ab_cdef, '0);
    add_tick(64'hfedc_ba98_7654_3210, OVR_W'(3));
    add_drain('1);
    add_tick(64'h8000_0000_0000_0001, '1);
    add_tick(64'h5555_aaaa_5555_aaaa, '0);
    add_drain(LIMIT_MAX);
    add_tick(64'h1111_2222_3333_4444, OVR_W'(70));
    add_tick(64'haaaa_5555_aaaa_5555, '0);
    add_tick(64'h7fff_ffff_ffff_fffe, OVR_W'(2));
    add_drain(LIM_W'(2));
    add_tick('1, OVR_W'(63));
    add_tick(64'h0000_0000_0000_00ff, OVR_W'(1));
    add_drain(LIM_W'(63));
    add_drain(LIM_W'(1));
    wait_queue_sent();

    add_random_items(50);
    wait_queue_sent();
    send_idle_pct = 57;
    add_random_items(50);
    wait_queue_sent();
    send_idle_pct = 0;
    recv_stall_pct = 57;
    add_random_items(50);
    wait_queue_sent();
    send_idle_pct = 15;
    recv_stall_pct = 15;
    add_random_items(50);
    wait_queue_sent();

    while (drain_beats_due.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("overwrite_ring_sample_buffer_unit_tb: done, clean");
    end else begin
      $display("overwrite_ring_sample_buffer_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/orsb_pkg.sv
rtl/orsb_ram.sv
rtl/overwrite_ring_sample_buffer_unit.sv
bench/overwrite_ring_sample_buffer_unit_tb.sv
